// ----- rtl/interval_max_overlap_defines.svh -----
// Assertion macros shared by the checker.
`ifndef INTERVAL_MAX_OVERLAP_DEFINES_SVH
`define INTERVAL_MAX_OVERLAP_DEFINES_SVH

// Same-cycle implication, off while reset is applied.
`define IMO_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is applied.
`define IMO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication, checked during reset as well.
`define IMO_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/imo_pkg.sv -----
package imo_pkg;

  localparam int MAX_INTERVALS_DEF = 1024;
  localparam int POS_WIDTH_DEF     = 32;
  localparam int IN_POS_W          = 32;
  localparam int OVL_W             = 11;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [OVL_W-1:0] OVL_SAT = {OVL_W{1'b1}};

  typedef struct packed {
    logic store;
    logic drop;
    logic last;
  } op_ctl_t;

endpackage

// ----- rtl/imo_front.sv -----
module imo_front #(
  parameter int MAX_INTERVALS = imo_pkg::MAX_INTERVALS_DEF,
  parameter int POS_WIDTH     = imo_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [imo_pkg::IN_POS_W-1:0] in_start,
  input  logic [imo_pkg::IN_POS_W-1:0] in_end,
  input  logic                         in_last,
  output logic [POS_WIDTH-1:0]         op_start,
  output logic [POS_WIDTH-1:0]         op_end,
  output imo_pkg::op_ctl_t             op_ctl
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);

  logic [CW-1:0] set_cnt_r;
  logic [CW-1:0] set_cnt_nxt;
  logic [63:0]   start_ext;
  logic [63:0]   end_ext;
  logic          room;

  assign start_ext = 64'(in_start);
  assign end_ext   = 64'(in_end);
  assign op_start  = start_ext[POS_WIDTH-1:0];
  assign op_end    = end_ext[POS_WIDTH-1:0];

  assign room         = (set_cnt_r < CW'(MAX_INTERVALS));
  assign op_ctl.store = room;
  assign op_ctl.drop  = !room;
  assign op_ctl.last  = in_last;

  always_comb begin
    set_cnt_nxt = set_cnt_r;
    if (accept) begin
      if (in_last) begin
        set_cnt_nxt = '0;
      end else if (room) begin
        set_cnt_nxt = set_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_cnt_r <= '0;
    end else begin
      set_cnt_r <= set_cnt_nxt;
    end
  end

endmodule

// ----- rtl/imo_queue.sv -----
module imo_queue #(
  parameter int POS_WIDTH = imo_pkg::POS_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [POS_WIDTH-1:0] push_start,
  input  logic [POS_WIDTH-1:0] push_end,
  input  imo_pkg::op_ctl_t     push_ctl,
  input  logic                 pop,
  output logic [POS_WIDTH-1:0] pop_start,
  output logic [POS_WIDTH-1:0] pop_end,
  output imo_pkg::op_ctl_t     pop_ctl,
  output logic                 empty,
  output logic                 full
);

  localparam int D  = imo_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);
  localparam int NW = $clog2(D + 1);

  logic [POS_WIDTH-1:0] q_start_r [D];
  logic [POS_WIDTH-1:0] q_end_r   [D];
  imo_pkg::op_ctl_t     q_ctl_r   [D];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == NW'(D));
  assign pop_start = q_start_r[rd_ptr_r];
  assign pop_end   = q_end_r[rd_ptr_r];
  assign pop_ctl   = q_ctl_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? PW'(rd_ptr_r + PW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_start_r[wr_ptr_r] <= push_start;
      q_end_r[wr_ptr_r]   <= push_end;
      q_ctl_r[wr_ptr_r]   <= push_ctl;
    end
  end

endmodule

// ----- rtl/imo_back.sv -----
module imo_back #(
  parameter int MAX_INTERVALS = imo_pkg::MAX_INTERVALS_DEF,
  parameter int POS_WIDTH     = imo_pkg::POS_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [POS_WIDTH-1:0]      q_start,
  input  logic [POS_WIDTH-1:0]      q_end,
  input  imo_pkg::op_ctl_t          q_ctl,
  output logic                      q_pop,
  output logic                      out_valid,
  output logic [imo_pkg::OVL_W-1:0] out_max_overlap,
  output logic                      out_overflow
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int IW = $clog2(MAX_INTERVALS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_PLOAD = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [POS_WIDTH-1:0] start_mem [MAX_INTERVALS];
  logic [POS_WIDTH-1:0] end_mem   [MAX_INTERVALS];

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        i_r, i_nxt;
  logic [CW-1:0]        j_r, j_nxt;
  logic [CW-1:0]        opened_r, opened_nxt;
  logic [CW-1:0]        closed_r, closed_nxt;
  logic [CW-1:0]        best_r, best_nxt;
  logic                 cmp_v_r;
  logic [POS_WIDTH-1:0] p_r;
  logic [POS_WIDTH-1:0] s_rd_r;
  logic [POS_WIDTH-1:0] e_rd_r;
  logic [IW-1:0]        rd_addr;
  logic [CW-1:0]        diff;
  logic [31:0]          best_w;
  logic                 out_valid_r;
  logic [imo_pkg::OVL_W-1:0] out_max_r;
  logic                 out_ovf_r;

  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign rd_addr = (state_r == S_FETCH) ? i_r[IW-1:0] : j_r[IW-1:0];
  assign diff    = opened_r - closed_r;
  assign best_w  = 32'(best_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    opened_nxt = opened_r;
    closed_nxt = closed_r;
    best_nxt   = best_r;
    if (cmp_v_r) begin
      opened_nxt = opened_r + CW'(s_rd_r < p_r);
      closed_nxt = closed_r + CW'(e_rd_r < p_r);
    end
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          count_nxt = count_r + CW'(q_ctl.store);
          ovf_nxt   = ovf_r | q_ctl.drop;
          if (q_ctl.last) begin
            i_nxt    = '0;
            best_nxt = '0;
            state_nxt = (count_nxt == '0) ? S_DONE : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_PLOAD;
      end
      S_PLOAD: begin
        opened_nxt = '0;
        closed_nxt = '0;
        j_nxt      = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        j_nxt = j_r + CW'(1);
        if (j_r == count_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (opened_r > closed_r && diff > best_r) begin
          best_nxt = diff;
        end
        i_nxt     = i_r + CW'(1);
        state_nxt = (i_nxt == count_r) ? S_DONE : S_FETCH;
      end
      S_DONE: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      cmp_v_r     <= (state_r == S_SCAN);
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    opened_r <= opened_nxt;
    closed_r <= closed_nxt;
    best_r   <= best_nxt;
    if (state_r == S_PLOAD) begin
      p_r <= e_rd_r;
    end
    if (state_r == S_DONE) begin
      out_max_r <= (best_w > 32'(imo_pkg::OVL_SAT)) ? imo_pkg::OVL_SAT
                                                    : best_w[imo_pkg::OVL_W-1:0];
      out_ovf_r <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_ctl.store) begin
      start_mem[count_r[IW-1:0]] <= q_start;
      end_mem[count_r[IW-1:0]]   <= q_end;
    end
    s_rd_r <= start_mem[rd_addr];
    e_rd_r <= end_mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_max_overlap = out_max_r;
  assign out_overflow    = out_ovf_r;

endmodule

// ----- rtl/interval_max_overlap.sv -----
// Loading: one interval per cycle while busy is low; a short queue feeds the store.
// Result: once older items have drained, the back end makes one compare pass over the N stored
// intervals per interval end, walking the store through its single read port (states fetch,
// load, scan, drain and eval per pass), then reaches done, and out_valid follows.
// out_valid strobes for one cycle with the result; the receiver cannot stall.
// Reset (rst_n low, synchronous): queue, set counters and result strobe clear;
// store contents are left as they are.
module interval_max_overlap #(
  parameter int MAX_INTERVALS = imo_pkg::MAX_INTERVALS_DEF,
  parameter int POS_WIDTH     = imo_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [imo_pkg::IN_POS_W-1:0] in_interval_start,
  input  logic [imo_pkg::IN_POS_W-1:0] in_interval_end,
  input  logic                         in_last_interval,
  output logic                         out_valid,
  output logic [imo_pkg::OVL_W-1:0]    out_max_overlap,
  output logic                         out_overflow
);

  logic                 accept;
  logic [POS_WIDTH-1:0] f_start, f_end;
  imo_pkg::op_ctl_t     f_ctl;
  logic [POS_WIDTH-1:0] q_start, q_end;
  imo_pkg::op_ctl_t     q_ctl;
  logic                 q_empty, q_full, q_pop;

  assign busy   = q_full;
  assign accept = start && !q_full;

  imo_front #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .POS_WIDTH    (POS_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_start(in_interval_start),
    .in_end  (in_interval_end),
    .in_last (in_last_interval),
    .op_start(f_start),
    .op_end  (f_end),
    .op_ctl  (f_ctl)
  );

  imo_queue #(
    .POS_WIDTH(POS_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_start(f_start),
    .push_end  (f_end),
    .push_ctl  (f_ctl),
    .pop       (q_pop),
    .pop_start (q_start),
    .pop_end   (q_end),
    .pop_ctl   (q_ctl),
    .empty     (q_empty),
    .full      (q_full)
  );

  imo_back #(
    .MAX_INTERVALS(MAX_INTERVALS),
    .POS_WIDTH    (POS_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_start        (q_start),
    .q_end          (q_end),
    .q_ctl          (q_ctl),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_max_overlap(out_max_overlap),
    .out_overflow   (out_overflow)
  );

endmodule

// ----- rtl/imo_checker.sv -----
`include "interval_max_overlap_defines.svh"

module imo_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      busy,
  input logic                      out_valid,
  input logic [imo_pkg::OVL_W-1:0] out_max_overlap,
  input logic                      out_overflow
);

  `IMO_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `IMO_ASSERT_NOW(a_result_known, clk, rst_n, out_valid, !$isunknown(out_max_overlap) && !$isunknown(out_overflow), "result fields unknown")
  `IMO_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid && !busy, "reset left outputs set")
  `IMO_ASSERT_NOW(a_idle_after_result, clk, rst_n, out_valid && $past(out_valid), 1'b0, "back-to-back results")

endmodule

bind interval_max_overlap imo_checker u_imo_checker (.*);

// ----- verif/imo_overlap_checker.sv -----
module imo_overlap_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [imo_pkg::IN_POS_W-1:0] in_interval_start,
  input  logic [imo_pkg::IN_POS_W-1:0] in_interval_end,
  input  logic                         in_last_interval,
  input  logic                         out_valid,
  input  logic [imo_pkg::OVL_W-1:0]    out_max_overlap,
  input  logic                         out_overflow,
  output int                           fail_count,
  output int                           results_owed
);
  import imo_pkg::*;

  typedef struct packed {
    logic [OVL_W-1:0] max_overlap;
    logic             overflow;
  } peak_result_t;

  logic [IN_POS_W-1:0] open_pos  [MAX_INTERVALS_DEF];
  logic [IN_POS_W-1:0] close_pos [MAX_INTERVALS_DEF];
  int                  held_count;
  logic                dropped_seen;
  peak_result_t        pending_peaks [$];
  peak_result_t        want;
  peak_result_t        fresh;

  // Sample the running count at every close position: opens strictly below it minus
  // closes strictly below it.
  function automatic logic [OVL_W-1:0] peak_cover_count(input int n);
    int                  best;
    int                  opened;
    int                  closed;
    logic [IN_POS_W-1:0] p;
    best = 0;
    for (int i = 0; i < n; i++) begin
      p = close_pos[i];
      opened = 0;
      closed = 0;
      for (int j = 0; j < n; j++) begin
        if (open_pos[j] < p) opened++;
        if (close_pos[j] < p) closed++;
      end
      if (opened - closed > best) best = opened - closed;
    end
    if (best > int'(OVL_SAT)) return OVL_SAT;
    return best[OVL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      dropped_seen = 1'b0;
      pending_peaks.delete();
      results_owed <= 0;
    end else begin
      if (out_valid) begin
        if (pending_peaks.size() == 0) begin
          $display("%0t: unexpected result max_overlap %0d overflow %0b", $time,
                   out_max_overlap, out_overflow);
          fail_count++;
        end else begin
          want = pending_peaks.pop_front();
          if (out_max_overlap !== want.max_overlap) begin
            $display("%0t: max_overlap expected %0d, actual %0d", $time,
                     want.max_overlap, out_max_overlap);
            fail_count++;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, actual %0b", $time,
                     want.overflow, out_overflow);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (held_count < MAX_INTERVALS_DEF) begin
          open_pos[held_count]  = in_interval_start;
          close_pos[held_count] = in_interval_end;
          held_count++;
        end else begin
          dropped_seen = 1'b1;
        end
        if (in_last_interval) begin
          fresh.max_overlap = peak_cover_count(held_count);
          fresh.overflow    = dropped_seen;
          pending_peaks.insert(pending_peaks.size(), fresh);
          held_count = 0;
          dropped_seen = 1'b0;
        end
      end
      results_owed <= pending_peaks.size();
    end
  end

endmodule

// ----- verif/interval_max_overlap_tb.sv -----
module interval_max_overlap_tb;
  import imo_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [IN_POS_W-1:0] in_interval_start = '0;
  logic [IN_POS_W-1:0] in_interval_end = '0;
  logic                in_last_interval = 1'b0;
  logic                out_valid;
  logic [OVL_W-1:0]    out_max_overlap;
  logic                out_overflow;
  int                  fail_count;
  int                  results_owed;

  int idle_tab [3] = '{0, 74, 14};

  always #2 clk = ~clk;

  interval_max_overlap dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_last_interval  (in_last_interval),
    .out_valid         (out_valid),
    .out_max_overlap   (out_max_overlap),
    .out_overflow      (out_overflow)
  );

  imo_overlap_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_interval_start (in_interval_start),
    .in_interval_end   (in_interval_end),
    .in_last_interval  (in_last_interval),
    .out_valid         (out_valid),
    .out_max_overlap   (out_max_overlap),
    .out_overflow      (out_overflow),
    .fail_count        (fail_count),
    .results_owed      (results_owed)
  );

  task automatic send_item(input logic [IN_POS_W-1:0] lo, input logic [IN_POS_W-1:0] hi,
                           input logic last, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_interval_start <= $urandom;
      in_interval_end <= $urandom;
      in_last_interval <= 1'($urandom_range(1));
      @(negedge clk);
    end
    start <= 1'b1;
    in_interval_start <= lo;
    in_interval_end <= hi;
    in_last_interval <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_set(input int count, input int idle_pct);
    logic [IN_POS_W-1:0] a;
    logic [IN_POS_W-1:0] b;
    logic [IN_POS_W-1:0] t;
    int                  shape;
    shape = $urandom_range(2);
    for (int k = 0; k < count; k++) begin
      case (shape)
        0: begin
          a = $urandom;
          b = $urandom;
        end
        1: begin
          a = $urandom_range(31);
          b = $urandom_range(31);
        end
        default: begin
          a = 32'hFFFF_FFE0 | $urandom_range(31);
          b = 32'hFFFF_FFE0 | $urandom_range(31);
        end
      endcase
      // keep most intervals well formed, leave a few reversed
      if (a > b && $urandom_range(7) != 0) begin
        t = a;
        a = b;
        b = t;
      end
      send_item(a, b, k == count - 1, idle_pct);
    end
  endtask

  initial begin
    int sent;
    int sz;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_item(32'h0, 32'h0, 1'b1, 0);
    send_item(32'h0, 32'hFFFF_FFFF, 1'b1, 0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 0);
    send_item(32'd0, 32'd5, 1'b0, 0);
    send_item(32'd5, 32'd10, 1'b1, 0);
    send_item(32'd3, 32'd7, 1'b0, 0);
    send_item(32'd3, 32'd7, 1'b0, 0);
    send_item(32'd3, 32'd7, 1'b1, 0);
    send_item(32'd10, 32'd5, 1'b0, 0);
    send_item(32'd0, 32'd20, 1'b1, 0);
    send_item(32'd5, 32'd5, 1'b0, 0);
    send_item(32'd4, 32'd5, 1'b0, 0);
    send_item(32'd0, 32'd100, 1'b0, 0);
    send_item(32'd50, 32'd60, 1'b1, 0);
    send_item(32'hFFFF_FFFF, 32'h0, 1'b1, 0);

    foreach (idle_tab[ph]) begin
      // fill the store around one common point, then drop two more, the last among them
      if (ph == 0) begin
        for (int k = 0; k < MAX_INTERVALS_DEF + 2; k++) begin
          if (k < MAX_INTERVALS_DEF)
            send_item($urandom_range(32'h7FFF_FFFF, 0),
                      $urandom_range(32'hFFFF_FFFF, 32'h8000_0000), 1'b0, idle_tab[ph]);
          else
            send_item($urandom, $urandom, k == MAX_INTERVALS_DEF + 1, idle_tab[ph]);
        end
      end
      sent = 0;
      while (sent < 50) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        run_set(sz, idle_tab[ph]);
        sent += sz;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/imo_pkg.sv
rtl/imo_front.sv
rtl/imo_queue.sv
rtl/imo_back.sv
rtl/interval_max_overlap.sv
rtl/imo_checker.sv
verif/imo_overlap_checker.sv
verif/interval_max_overlap_tb.sv
